// File: rtl/ufr_pkg.sv
// Shared types, constants and tables for the UART fragment reassembler.
`timescale 1ns / 1ps
package ufr_pkg;

  localparam int CHUNK_BYTES  = 17;
  localparam int FRAME_BYTES  = 20;
  localparam int HEADER_BYTES = 3;

  localparam int BYTE_W = 8;
  localparam int ADDR_W = 13;
  localparam int EXP_W  = 4;
  localparam int SIZE_W = 8;
  localparam int POS_W  = $clog2(FRAME_BYTES);
  localparam int PROD_W = BYTE_W + $clog2(CHUNK_BYTES + 1);

  localparam int TDATA_W = 32;
  localparam int TUSER_W = 3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_NAK   = 2'd2
  } kind_t;

  // Work queued per received byte: an optional payload write, then an optional response.
  typedef struct packed {
    logic              has_wr;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic              has_resp;
    logic              nak;
    logic              done;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic              done;
    logic [SIZE_W-1:0] size;
  } result_t;

  typedef logic [(1 << BYTE_W)-1:0][EXP_W-1:0] frames_table_t;

  // Frames needed for a message size: ceil(size / CHUNK_BYTES), low bits kept.
  function automatic frames_table_t build_frames_table();
    frames_table_t tbl;
    for (int i = 0; i < (1 << BYTE_W); i++) begin
      tbl[i] = EXP_W'((i + CHUNK_BYTES - 1) / CHUNK_BYTES);
    end
    return tbl;
  endfunction

  localparam frames_table_t FRAMES_TABLE = build_frames_table();

endpackage

// File: rtl/uart_fragment_reassembler_top.sv
// Top level of the UART fragment reassembler.
//
//  channel | direction | tdata (low bit up)                             | tuser
//  s_*     | in        | rx_byte[7:0]                                   | -
//  m_*     | out       | write_address[12:0], write_data[7:0],          | kind[1:0],
//          |           | message_size[7:0], zero fill to 32 bits        | message_done
//
// One byte is accepted per cycle; results leave one per cycle through a registered
// output while m_tready is high. The last byte of an accepted frame gives two results
// (write, then ack), and a four-entry queue absorbs the extra one. Input stalls only
// when the queue is full. Synchronous reset clears frame position, message tracking
// and the queue.
`timescale 1ns / 1ps
module uart_fragment_reassembler_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ufr_pkg::BYTE_W-1:0]    s_tdata,   // rx_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ufr_pkg::TDATA_W-1:0]   m_tdata,   // write_address, write_data, message_size
  output logic [ufr_pkg::TUSER_W-1:0]   m_tuser    // kind, message_done
);

  logic             push;
  ufr_pkg::entry_t  push_entry;
  logic             pop;
  ufr_pkg::entry_t  head;
  logic             full;
  logic             empty;
  ufr_pkg::result_t res;

  ufr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_byte    (s_tdata),
    .queue_full (full),
    .in_ready   (s_tready),
    .push       (push),
    .push_entry (push_entry)
  );

  ufr_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  ufr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (res)
  );

  assign m_tdata = ufr_pkg::TDATA_W'({res.size, res.data, res.addr});
  assign m_tuser = {res.done, res.kind};

endmodule

// File: rtl/ufr_front.sv
// Front end: tracks frame position, checks id and sequence, queues writes and responses.
`timescale 1ns / 1ps
module ufr_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [ufr_pkg::BYTE_W-1:0]       in_byte,
  input  logic                             queue_full,
  output logic                             in_ready,
  output logic                             push,
  output ufr_pkg::entry_t                  push_entry
);

  logic [ufr_pkg::POS_W-1:0]  pos;
  logic [ufr_pkg::BYTE_W-1:0] cur_id;
  logic [ufr_pkg::BYTE_W-1:0] frames_rx;
  logic [ufr_pkg::EXP_W-1:0]  exp_frames;
  logic [ufr_pkg::SIZE_W-1:0] msg_len;
  logic [ufr_pkg::BYTE_W-1:0] lat_id;
  logic [ufr_pkg::BYTE_W-1:0] lat_seq;
  logic                       accepted;
  logic [ufr_pkg::ADDR_W-1:0] base;

  logic                       take;
  logic                       last_byte;
  logic                       new_msg;
  logic [ufr_pkg::BYTE_W-1:0] frames_base;
  logic                       seq_ok;
  logic [ufr_pkg::PROD_W-1:0] base_prod;
  logic                       done;

  assign in_ready  = !queue_full;
  assign take      = in_valid && in_ready;
  assign last_byte = pos >= ufr_pkg::POS_W'(ufr_pkg::FRAME_BYTES - 1);

  assign new_msg     = lat_id != cur_id;
  assign frames_base = new_msg ? '0 : frames_rx;
  assign seq_ok      = (lat_seq != '0) &&
                       ({1'b0, frames_base} + 9'd1 == {1'b0, lat_seq});

  assign base_prod = ufr_pkg::PROD_W'(in_byte - 8'd1) *
                     ufr_pkg::PROD_W'(ufr_pkg::CHUNK_BYTES);

  assign done = {{(ufr_pkg::BYTE_W - ufr_pkg::EXP_W){1'b0}}, exp_frames} == frames_rx;

  always_comb begin
    push_entry          = '0;
    push_entry.has_wr   = (pos > ufr_pkg::POS_W'(2)) && accepted;
    push_entry.addr     = base + ufr_pkg::ADDR_W'(pos - ufr_pkg::POS_W'(ufr_pkg::HEADER_BYTES));
    push_entry.data     = in_byte;
    push_entry.has_resp = last_byte;
    push_entry.nak      = !accepted;
    push_entry.done     = accepted && done;
    push_entry.size     = (accepted && done) ? msg_len : '0;
    push                = take && (push_entry.has_wr || push_entry.has_resp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      cur_id     <= '0;
      frames_rx  <= '0;
      exp_frames <= '0;
      msg_len    <= '0;
      lat_id     <= '0;
      lat_seq    <= '0;
      accepted   <= 1'b0;
      base       <= '0;
    end else if (take) begin
      if (pos == ufr_pkg::POS_W'(0)) begin
        lat_id <= in_byte;
      end else if (pos == ufr_pkg::POS_W'(1)) begin
        lat_seq <= in_byte;
        base    <= ufr_pkg::ADDR_W'(base_prod);
      end else if (pos == ufr_pkg::POS_W'(2)) begin
        // restart the message on a new id, then check the sequence
        if (new_msg) begin
          cur_id     <= lat_id;
          msg_len    <= in_byte;
          exp_frames <= ufr_pkg::FRAMES_TABLE[in_byte];
        end
        frames_rx <= seq_ok ? lat_seq : frames_base;
        accepted  <= seq_ok;
      end
      if (last_byte) begin
        pos      <= '0;
        accepted <= 1'b0;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule

// File: rtl/ufr_fifo.sv
// Short queue of pending work between the front and back ends.
`timescale 1ns / 1ps
module ufr_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ufr_pkg::entry_t push_entry,
  input  logic            pop,
  output ufr_pkg::entry_t head,
  output logic            full,
  output logic            empty
);

  ufr_pkg::entry_t                mem [ufr_pkg::FIFO_DEPTH];
  logic [ufr_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [ufr_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [ufr_pkg::FIFO_CNT_W-1:0] count;

  assign head  = mem[rd_ptr];
  assign empty = count == '0;
  assign full  = count == ufr_pkg::FIFO_CNT_W'(ufr_pkg::FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/ufr_back.sv
// Back end: splits queued work into single results and holds them in the output register.
`timescale 1ns / 1ps
module ufr_back (
  input  logic              clk,
  input  logic              rst,
  input  ufr_pkg::entry_t   head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output ufr_pkg::result_t  out_result
);

  logic wr_sent;
  logic slot_free;
  logic send;
  logic emit_wr;

  assign slot_free = !out_valid || out_ready;
  assign send      = slot_free && !empty;
  assign emit_wr   = head.has_wr && !wr_sent;
  // pop once the last request of the entry goes out
  assign pop       = send && (!emit_wr || !head.has_resp);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      wr_sent   <= 1'b0;
    end else begin
      if (slot_free) begin
        out_valid <= !empty;
      end
      if (send) begin
        wr_sent <= emit_wr && head.has_resp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      if (emit_wr) begin
        out_result.kind <= ufr_pkg::KIND_WRITE;
        out_result.addr <= head.addr;
        out_result.data <= head.data;
        out_result.done <= 1'b0;
        out_result.size <= '0;
      end else begin
        out_result.kind <= head.nak ? ufr_pkg::KIND_NAK : ufr_pkg::KIND_ACK;
        out_result.addr <= '0;
        out_result.data <= '0;
        out_result.done <= head.done;
        out_result.size <= head.size;
      end
    end
  end

endmodule

// File: bench/ufr_stream_checker.sv
// Stream checker for the UART fragment reassembler: predicts results per received byte and compares.
`timescale 1ns / 1ps
module ufr_stream_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [ufr_pkg::BYTE_W-1:0]  s_tdata,   // rx_byte
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [ufr_pkg::TDATA_W-1:0] m_tdata,   // write_address, write_data, message_size
  input  logic [ufr_pkg::TUSER_W-1:0] m_tuser,   // kind, message_done
  output int                          failures,
  output int                          outstanding
);
  import ufr_pkg::*;

  localparam int REPORT_LIMIT = 10;

  logic [POS_W-1:0]  frame_pos;
  logic [BYTE_W-1:0] msg_id;
  logic [BYTE_W-1:0] frames_seen;
  logic [EXP_W-1:0]  frames_needed;
  logic [SIZE_W-1:0] msg_size;
  logic [BYTE_W-1:0] hdr_id;
  logic [BYTE_W-1:0] hdr_seq;
  logic              frame_ok;

  result_t expected_results[$];

  task automatic predict_byte(input logic [BYTE_W-1:0] b);
    int addr;
    int needed;
    logic done;
    if (frame_pos == 0) begin
      hdr_id = b;
    end else if (frame_pos == 1) begin
      hdr_seq = b;
    end else if (frame_pos == 2) begin
      // a new id restarts the message and takes its size from this byte
      if (hdr_id != msg_id) begin
        needed = (int'(b) + CHUNK_BYTES - 1) / CHUNK_BYTES;
        msg_id = hdr_id;
        frames_seen = '0;
        msg_size = b;
        frames_needed = EXP_W'(needed);
      end
      if (hdr_seq != 0 && ({1'b0, frames_seen} + 9'd1) == {1'b0, hdr_seq}) begin
        frames_seen = hdr_seq;
        frame_ok = 1'b1;
      end else begin
        frame_ok = 1'b0;
      end
    end else if (frame_ok) begin
      addr = (int'(hdr_seq) - 1) * CHUNK_BYTES + int'(frame_pos) - HEADER_BYTES;
      expected_results.push_back('{kind: KIND_WRITE, addr: ADDR_W'(addr), data: b,
                                   done: 1'b0, size: '0});
    end
    if (frame_pos == FRAME_BYTES - 1) begin
      if (frame_ok) begin
        done = ({{(BYTE_W - EXP_W){1'b0}}, frames_needed} == frames_seen);
        expected_results.push_back('{kind: KIND_ACK, addr: '0, data: '0, done: done,
                                     size: done ? msg_size : '0});
      end else begin
        expected_results.push_back('{kind: KIND_NAK, addr: '0, data: '0, done: 1'b0,
                                     size: '0});
      end
      frame_pos = '0;
      frame_ok = 1'b0;
    end else begin
      frame_pos = frame_pos + 1'b1;
    end
  endtask

  task automatic check_result();
    result_t got;
    result_t want;
    got.kind = kind_t'(m_tuser[1:0]);
    got.done = m_tuser[2];
    got.addr = m_tdata[ADDR_W-1:0];
    got.data = m_tdata[ADDR_W +: BYTE_W];
    got.size = m_tdata[ADDR_W + BYTE_W +: SIZE_W];
    if (expected_results.size() == 0) begin
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("unexpected result: kind=%0d addr=%0d data=%02h done=%0d size=%0d",
                 got.kind, got.addr, got.data, got.done, got.size);
    end else begin
      want = expected_results.pop_front();
      if (got.kind != want.kind || got.addr != want.addr || got.data != want.data ||
          got.done != want.done || got.size != want.size) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display({"mismatch: expected kind=%0d addr=%0d data=%02h done=%0d size=%0d,",
                    " got kind=%0d addr=%0d data=%02h done=%0d size=%0d"},
                   want.kind, want.addr, want.data, want.done, want.size,
                   got.kind, got.addr, got.data, got.done, got.size);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_pos = '0;
      msg_id = '0;
      frames_seen = '0;
      frames_needed = '0;
      msg_size = '0;
      hdr_id = '0;
      hdr_seq = '0;
      frame_ok = 1'b0;
      expected_results.delete();
      failures = 0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready) predict_byte(s_tdata);
    end
    outstanding = expected_results.size();
  end

endmodule

// File: bench/uart_fragment_reassembler_top_tb.sv
// Testbench top for the UART fragment reassembler: reset, frame stimulus, pacing and verdict.
`timescale 1ns / 1ps
module uart_fragment_reassembler_top_tb;
  import ufr_pkg::*;

  typedef enum int {
    PACE_STEADY,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH,
    PACE_DRAIN
  } pace_t;

  localparam int RANDOM_BYTES = 1650;
  localparam int HOLD_START   = 120;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 30;
  localparam int TIMEOUT_NS   = 4_000_000;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [BYTE_W-1:0]   s_tdata;   // rx_byte
  logic                m_tvalid;
  logic                m_tready;
  logic [TDATA_W-1:0]  m_tdata;   // write_address, write_data, message_size
  logic [TUSER_W-1:0]  m_tuser;   // kind, message_done

  int    failures;
  int    outstanding;
  pace_t pace = PACE_STEADY;
  int    bytes_sent;
  int    gap_pct[5]   = '{0, 74, 0, 19, 0};
  int    stall_pct[5] = '{0, 0, 74, 19, 0};
  logic [BYTE_W-1:0] last_id;

  always #10 clk = ~clk;

  uart_fragment_reassembler_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  ufr_stream_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < gap_pct[pace]) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] seq,
                            input logic [BYTE_W-1:0] size);
    int r;
    send_byte(id);
    send_byte(seq);
    send_byte(size);
    for (int i = 0; i < FRAME_BYTES - HEADER_BYTES; i++) begin
      r = $urandom_range(0, 9);
      send_byte(r == 0 ? 8'h00 : r == 1 ? 8'hFF : BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // One message: mostly in-order frames, with some zero, random and repeated sequences.
  task automatic send_message();
    logic [BYTE_W-1:0] id;
    logic [BYTE_W-1:0] size;
    int frames;
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      id = last_id;
    end else begin
      do id = BYTE_W'($urandom_range(0, 255)); while (id == last_id);
    end
    last_id = id;
    r = $urandom_range(0, 99);
    if (r < 8) size = 8'd0;
    else if (r < 80) size = BYTE_W'($urandom_range(1, 68));
    else size = BYTE_W'($urandom_range(69, 255));
    frames = (int'(size) + CHUNK_BYTES - 1) / CHUNK_BYTES;
    if (frames == 0) frames = $urandom_range(1, 3);
    for (int s = 1; s <= frames; s++) begin
      r = $urandom_range(0, 99);
      if (r < 4) send_frame(id, 8'd0, BYTE_W'($urandom_range(0, 255)));
      else if (r < 8) send_frame(id, BYTE_W'($urandom_range(0, 255)),
                                 BYTE_W'($urandom_range(0, 255)));
      else if (r < 11 && s > 1) send_frame(id, BYTE_W'(s - 1), BYTE_W'($urandom_range(0, 255)));
      send_frame(id, BYTE_W'(s), s == 1 ? size : BYTE_W'($urandom_range(0, 255)));
    end
    // a frame past completion is accepted but must not flag completion again
    if ($urandom_range(0, 99) < 10) send_frame(id, BYTE_W'(frames + 1), 8'd0);
  endtask

  // Receiver: random stalls per pace, plus one long hold-off to back up the input.
  initial begin
    int hold_wait;
    logic held;
    hold_wait = 0;
    held = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && !rst && pace == PACE_STEADY) hold_wait++;
      if (!held && hold_wait == HOLD_START) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          m_tready <= 1'b0;
          @(negedge clk);
        end
      end
      m_tready <= ($urandom_range(0, 99) >= stall_pct[pace]);
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    bytes_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // id zero matches the reset id: accepted, but the message can never complete
    send_frame(8'h00, 8'd1, 8'd5);
    // new id with size zero and sequence zero: restart, then nak
    send_frame(8'hFF, 8'd0, 8'd0);
    last_id = 8'hFF;

    bytes_sent = 0;
    for (int p = PACE_STEADY; p <= PACE_BOTH; p++) begin
      pace = pace_t'(p);
      while (bytes_sent < (p + 1) * RANDOM_BYTES / 4) send_message();
    end
    s_tvalid <= 1'b0;
    pace = PACE_DRAIN;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("uart_fragment_reassembler_top test passed");
    end else begin
      $display("uart_fragment_reassembler_top test failed");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("uart_fragment_reassembler_top test failed");
    $finish;
  end

endmodule

// File: uart_fragment_reassembler_top.f
rtl/ufr_pkg.sv
rtl/ufr_front.sv
rtl/ufr_fifo.sv
rtl/ufr_back.sv
rtl/uart_fragment_reassembler_top.sv
bench/ufr_stream_checker.sv
bench/uart_fragment_reassembler_top_tb.sv
